// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, clocked on clk and held off while rst_n is low.
`define GFAU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("gfau check failed");

// Same, with the consequent checked in the cycle after the antecedent.
`define GFAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  `GFAU_ASSERT(label, clk, rst_n, (ante) |=> (cons))

`endif

// ===== sv/gfau_pkg.sv =====
// Package: GF(2^8) field helpers, opcodes and pipeline types.
package gfau_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CmdW  = 2;

  // Low byte of the field polynomial 0x11b, the zero-divisor scale and the
  // fixed multipliers for xtime and times three.
  localparam logic [ByteW-1:0] GfReduce  = 8'h1b;
  localparam logic [ByteW-1:0] ZeroDivMul = 8'hff;
  localparam logic [ByteW-1:0] GfTwo     = 8'h02;
  localparam logic [ByteW-1:0] GfThree   = 8'h03;

  typedef enum logic [CmdW-1:0] {
    CMD_MUL = 2'd0,
    CMD_DIV = 2'd1,
    CMD_X2  = 2'd2,
    CMD_X3  = 2'd3
  } gfau_cmd_e;

  // Item entering the inverse pipeline.
  typedef struct packed {
    logic             valid;
    gfau_cmd_e        cmd;
    logic [ByteW-1:0] a;
    logic [ByteW-1:0] b;
  } gfau_item_t;

  // Operand pair handed to the final multiply stage.
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] a;
    logic [ByteW-1:0] mult;
    logic             div_zero;
  } gfau_op_t;

  function automatic logic [ByteW-1:0] gf_xtime(input logic [ByteW-1:0] v);
    logic [ByteW-1:0] s;
    s = {v[ByteW-2:0], 1'b0};
    if (v[ByteW-1]) begin
      s = s ^ GfReduce;
    end
    return s;
  endfunction

  // Shift-and-add multiply, reduced on every step.
  function automatic logic [ByteW-1:0] gf_mul(input logic [ByteW-1:0] x,
                                              input logic [ByteW-1:0] y);
    logic [ByteW-1:0] acc;
    logic [ByteW-1:0] xs;
    acc = '0;
    xs  = x;
    for (int i = 0; i < ByteW; i++) begin
      if (y[i]) begin
        acc = acc ^ xs;
      end
      xs = gf_xtime(xs);
    end
    return acc;
  endfunction

  // Squaring is linear over GF(2); synthesis folds this to an XOR net.
  function automatic logic [ByteW-1:0] gf_sq(input logic [ByteW-1:0] x);
    return gf_mul(x, x);
  endfunction

endpackage

// ===== sv/gfau_if.sv =====
// Valid/ready channel interfaces for operand and result beats.
interface gfau_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] operand_a;
  logic [7:0] operand_b;

  modport source (output valid, output cmd, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input cmd, input operand_a, input operand_b,
                output ready);
endinterface

interface gfau_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result;
  logic       divisor_zero;

  modport source (output valid, output result, output divisor_zero, input ready);
  modport sink (input valid, input result, input divisor_zero, output ready);
endinterface

// ===== sv/gf256_arithmetic_unit.sv =====
// Top level: GF(2^8) arithmetic unit over x^8+x^4+x^3+x+1.
// An accepted operand beat passes the s1, s2, s3 and output registers to its result beat.
// Throughput: one beat per cycle unless the output stalls; the four register stages advance together.
// A stalled output freezes the whole pipe, so no beat is dropped or repeated.
// Reset (rst_ni low, async) clears the stage valid bits only; no state else.
module gf256_arithmetic_unit (
  input  logic clk_i,
  input  logic rst_ni,
  gfau_in_if.sink    in_i,
  gfau_out_if.source out_o
);
  import gfau_pkg::*;

  // Every operation reduces to a * m, with m chosen per command:
  //   multiply -> b, divide -> b^254 (0xff for b == 0), xtime -> 2, x3 -> 3.
  // Stages 1..3 build b^254 as a product tree of the squares of b:
  //   s1: b^6, b^24, b^96, b^128   s2: b^30, b^224   s3: b^254 and select.
  // Stage 4 does the a * m multiply into the output register.

  gfau_item_t item;
  gfau_op_t   op;
  logic       pipe_en;
  logic       out_valid;

  // Pipe moves whenever the output register is empty or being drained.
  assign pipe_en  = !out_valid || out_o.ready;
  assign in_i.ready = pipe_en;

  assign item.valid = in_i.valid;
  assign item.cmd   = gfau_cmd_e'(in_i.cmd);
  assign item.a     = in_i.operand_a;
  assign item.b     = in_i.operand_b;

  gfau_inv_pipe u_inv_pipe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .item_i (item),
    .op_o   (op)
  );

  gfau_mul_stage u_mul_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (pipe_en),
    .op_i       (op),
    .valid_o    (out_valid),
    .result_o   (out_o.result),
    .div_zero_o (out_o.divisor_zero)
  );

  assign out_o.valid = out_valid;

endmodule

// ===== sv/gfau_inv_pipe.sv =====
// Three-stage b^254 inverse pipeline and multiplier operand select.
module gfau_inv_pipe (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  gfau_pkg::gfau_item_t item_i,
  output gfau_pkg::gfau_op_t   op_o
);
  import gfau_pkg::*;

  // Stage 1: b^6, b^24, b^96, b^128
  logic             s1_valid_q;
  gfau_cmd_e        s1_cmd_q;
  logic [ByteW-1:0] s1_a_q, s1_b_q, s1_p_q, s1_q_q, s1_r_q, s1_s_q;
  // Stage 2: b^30, b^224
  logic             s2_valid_q;
  gfau_cmd_e        s2_cmd_q;
  logic [ByteW-1:0] s2_a_q, s2_b_q, s2_u_q, s2_v_q;
  // Stage 3: selected multiplier
  logic             s3_valid_q;
  logic [ByteW-1:0] s3_a_q, s3_mult_q;
  logic             s3_dz_q;

  logic [ByteW-1:0] b2, b4, b8, b16, b32, b64, b128;
  logic [ByteW-1:0] s1_p_d, s1_q_d, s1_r_d;
  logic [ByteW-1:0] s2_u_d, s2_v_d;
  logic [ByteW-1:0] inv, s3_mult_d;
  logic             s3_dz_d;

  always_comb begin
    b2     = gf_sq(item_i.b);
    b4     = gf_sq(b2);
    b8     = gf_sq(b4);
    b16    = gf_sq(b8);
    b32    = gf_sq(b16);
    b64    = gf_sq(b32);
    b128   = gf_sq(b64);
    s1_p_d = gf_mul(b2, b4);
    s1_q_d = gf_mul(b8, b16);
    s1_r_d = gf_mul(b32, b64);
  end

  always_comb begin
    s2_u_d = gf_mul(s1_p_q, s1_q_q);
    s2_v_d = gf_mul(s1_r_q, s1_s_q);
  end

  always_comb begin
    inv       = gf_mul(s2_u_q, s2_v_q);
    s3_dz_d   = 1'b0;
    s3_mult_d = s2_b_q;
    unique case (s2_cmd_q)
      CMD_MUL: s3_mult_d = s2_b_q;
      CMD_DIV: begin
        // zero divisor: scale by 0xff and flag it
        if (s2_b_q == '0) begin
          s3_mult_d = ZeroDivMul;
          s3_dz_d   = 1'b1;
        end else begin
          s3_mult_d = inv;
        end
      end
      CMD_X2:  s3_mult_d = GfTwo;
      CMD_X3:  s3_mult_d = GfThree;
      default: s3_mult_d = s2_b_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= item_i.valid;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_cmd_q  <= item_i.cmd;
      s1_a_q    <= item_i.a;
      s1_b_q    <= item_i.b;
      s1_p_q    <= s1_p_d;
      s1_q_q    <= s1_q_d;
      s1_r_q    <= s1_r_d;
      s1_s_q    <= b128;
      s2_cmd_q  <= s1_cmd_q;
      s2_a_q    <= s1_a_q;
      s2_b_q    <= s1_b_q;
      s2_u_q    <= s2_u_d;
      s2_v_q    <= s2_v_d;
      s3_a_q    <= s2_a_q;
      s3_mult_q <= s3_mult_d;
      s3_dz_q   <= s3_dz_d;
    end
  end

  assign op_o.valid    = s3_valid_q;
  assign op_o.a        = s3_a_q;
  assign op_o.mult     = s3_mult_q;
  assign op_o.div_zero = s3_dz_q;

endmodule

// ===== sv/gfau_mul_stage.sv =====
// Final field multiply and output register.
module gfau_mul_stage (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  gfau_pkg::gfau_op_t      op_i,
  output logic                    valid_o,
  output logic [gfau_pkg::ByteW-1:0] result_o,
  output logic                    div_zero_o
);
  import gfau_pkg::*;

  logic             valid_q;
  logic [ByteW-1:0] result_q, result_d;
  logic             dz_q;

  assign result_d = gf_mul(op_i.a, op_i.mult);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= op_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      result_q <= result_d;
      dz_q     <= op_i.div_zero;
    end
  end

  assign valid_o    = valid_q;
  assign result_o   = result_q;
  assign div_zero_o = dz_q;

endmodule

// ===== sv/gfau_checker.sv =====
// Port-level checker for the GF(2^8) unit, bound to the top level.
`include "assert_macros.svh"

module gfau_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_cmd_i,
  input logic [7:0] in_a_i,
  input logic [7:0] in_b_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_result_i,
  input logic       out_dz_i
);
  import gfau_pkg::*;

  logic in_acc;
  logic div_by_zero;
  logic no_div;
  logic zero_prod;

  assign in_acc      = in_valid_i && in_ready_i;
  assign div_by_zero = in_acc && (in_cmd_i == CMD_DIV) && (in_b_i == '0);
  assign no_div      = in_acc && (in_cmd_i != CMD_DIV);
  assign zero_prod   = in_acc && (in_cmd_i == CMD_MUL) && ((in_a_i == '0) || (in_b_i == '0));

  // Stalled result beat holds its payload.
  `GFAU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(out_result_i) && $stable(out_dz_i))

  // With the sink ready while it crosses the pipeline registers, a zero-divisor beat comes out flagged.
  `GFAU_ASSERT_NEXT(a_dz_flag, clk_i, rst_ni,
    div_by_zero ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i, out_valid_i && out_dz_i)

  // Non-divide operations never raise the flag.
  `GFAU_ASSERT_NEXT(a_no_flag, clk_i, rst_ni,
    no_div ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i, out_valid_i && !out_dz_i)

  // Multiply by zero gives zero.
  `GFAU_ASSERT_NEXT(a_mul_zero, clk_i, rst_ni,
    zero_prod ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i,
    out_valid_i && (out_result_i == '0))

endmodule

bind gf256_arithmetic_unit gfau_checker u_gfau_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_cmd_i     (in_i.cmd),
  .in_a_i       (in_i.operand_a),
  .in_b_i       (in_i.operand_b),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_result_i (out_o.result),
  .out_dz_i     (out_o.divisor_zero)
);
